FILE: design/bis_pkg.sv
package bis_pkg;

    // Number of cells in the sorting chain.
    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    // Controls that the top level sends to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

FILE: design/binary_insertion_sorter_unit.sv
// Channel  Handshake            Ports
// input    start & !busy        value, is_last
// result   strobe (one cycle)   sorted_value, end_of_run, truncated
//
// Each accepted word is inserted into the cell chain in the cycle it arrives,
// so words of a run can be taken in back-to-back cycles.
// A word with is_last set starts the drain: the chain shifts toward cell 0 and
// one result per held value comes out, one per cycle, N results for N held.
// busy is high while the chain drains; the next run can start only once the drain is over.
// The receiver cannot hold results off, so nothing on the output side stalls.
// Reset empties the chain at once; no clearing pass is needed.
module binary_insertion_sorter_unit
    import bis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     is_last,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     end_of_run,
    output logic                     truncated
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     strobe_reg;
    logic                     strobe_next;
    logic                     eor_reg;
    logic                     eor_next;
    logic                     trunc_reg;
    logic                     trunc_next;
    logic signed [DATA_W-1:0] out_value_reg;

    logic                     accept;
    logic                     full;
    cell_ctrl_t               ctrl;
    logic [CNT_W-1:0]         count_after;

    logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
    logic                     cell_valid [MAX_ITEMS];
    logic                     cell_ins   [MAX_ITEMS];

    assign busy        = (state_reg == ST_EMIT);
    assign accept      = start && !busy;
    assign full        = (count_reg == CNT_W'(MAX_ITEMS));
    assign count_after = full ? count_reg : count_reg + 1'b1;

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = busy;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] lv;
            logic                     lvalid;
            logic                     lins;
            logic signed [DATA_W-1:0] rv;
            logic                     rvalid;

            if (gi == 0)
            begin : g_first
                assign lv     = '0;
                assign lvalid = 1'b0;
                assign lins   = 1'b0;
            end
            else
            begin : g_mid
                assign lv     = cell_value[gi-1];
                assign lvalid = cell_valid[gi-1];
                assign lins   = cell_ins[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign rv     = '0;
                assign rvalid = 1'b0;
            end
            else
            begin : g_body
                assign rv     = cell_value[gi+1];
                assign rvalid = cell_valid[gi+1];
            end

            bis_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key         (value),
                .left_value  (lv),
                .left_valid  (lvalid),
                .left_ins    (lins),
                .right_value (rv),
                .right_valid (rvalid),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .ins         (cell_ins[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        ovf_next    = ovf_reg;
        strobe_next = 1'b0;
        eor_next    = 1'b0;
        trunc_next  = trunc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ovf_next = ovf_reg || full;
                    if (is_last)
                    begin
                        state_next  = ST_EMIT;
                        remain_next = count_after;
                        count_next  = '0;
                    end
                    else
                    begin
                        count_next = count_after;
                    end
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                eor_next    = (remain_reg == CNT_W'(1));
                trunc_next  = ovf_reg;
                remain_next = remain_reg - 1'b1;
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            eor_reg    <= 1'b0;
            trunc_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
            eor_reg    <= eor_next;
            trunc_reg  <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            out_value_reg <= cell_value[0];
        end
    end

    assign strobe       = strobe_reg;
    assign sorted_value = out_value_reg;
    assign end_of_run   = eor_reg;
    assign truncated    = trunc_reg;

    // A result word only ever follows a drain cycle.
    a_strobe_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result word without a preceding drain cycle");

    // The final word of a run leaves the block idle.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && end_of_run |-> !busy)
        else $error("busy still high after the final word of a run");

    // While draining, the head cell always holds a value.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cell_valid[0] && remain_reg != '0)
        else $error("drain with an empty chain");

    // A word arriving at a full chain marks the run as truncated.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full |=> ovf_reg)
        else $error("dropped word did not set the overflow flag");

endmodule

FILE: design/bis_cell.sv
module bis_cell
    import bis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_valid,
    input  logic                     left_ins,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic                     right_valid,
    output logic signed [DATA_W-1:0] value,
    output logic                     valid,
    output logic                     ins
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;

    // The key belongs at or before this slot when the slot is empty or holds a
    // strictly greater value, so equal keys land to the right of older ones.
    assign ins = !valid_reg || (key < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (ins)
            begin
                if (left_ins)
                begin
                    value_next = left_value;
                    valid_next = left_valid;
                end
                else
                begin
                    value_next = key;
                    valid_next = 1'b1;
                end
            end
        end
        else if (ctrl.drain)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: bench/bis_result_checker.sv
module bis_result_checker
    import bis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     is_last,
    input  logic                     strobe,
    input  logic signed [DATA_W-1:0] sorted_value,
    input  logic                     end_of_run,
    input  logic                     truncated,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     truncated;
    } sort_result_t;

    logic signed [DATA_W-1:0] run_store[$];
    logic                     run_dropped;
    sort_result_t             sorted_due[$];

    // Places one word into the held run, or drops it when the run is full; a word that
    // closes the run releases the whole run, smallest first, as expected results.
    task automatic sort_word(input logic signed [DATA_W-1:0] v, input logic closes_run);
        int           lo;
        int           hi;
        int           mid;
        sort_result_t r;
        if (run_store.size() >= MAX_ITEMS) begin
            run_dropped = 1'b1;
        end
        else begin
            lo = 0;
            hi = run_store.size();
            // Equal keys land to the right of those already held.
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (v < run_store[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            run_store.insert(lo, v);
        end
        if (closes_run) begin
            foreach (run_store[k]) begin
                r.sorted_value = run_store[k];
                r.end_of_run   = (k == run_store.size() - 1);
                r.truncated    = run_dropped;
                sorted_due.push_back(r);
            end
            run_store.delete();
            run_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        sort_result_t exp_r;
        if (sorted_due.size() == 0) begin
            $error("result word with none expected: sorted_value %0d end_of_run %0b truncated %0b",
                   sorted_value, end_of_run, truncated);
            fail_count++;
        end
        else begin
            exp_r = sorted_due.pop_front();
            checked++;
            if (sorted_value !== exp_r.sorted_value) begin
                $error("sorted_value: expected %0d, got %0d", exp_r.sorted_value, sorted_value);
                fail_count++;
            end
            if (end_of_run !== exp_r.end_of_run) begin
                $error("end_of_run: expected %0b, got %0b", exp_r.end_of_run, end_of_run);
                fail_count++;
            end
            if (truncated !== exp_r.truncated) begin
                $error("truncated: expected %0b, got %0b", exp_r.truncated, truncated);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_store.delete();
            sorted_due.delete();
            run_dropped = 1'b0;
        end
        else begin
            // The accepted word is taken first so that any result it causes
            // is already expected when the strobe is looked at.
            if (start && !busy)
                sort_word(value, is_last);
            if (strobe)
                check_result();
        end
        pending = sorted_due.size();
    end

endmodule

FILE: bench/tb_binary_insertion_sorter_unit.sv
module tb_binary_insertion_sorter_unit;
    import bis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = MAX_ITEMS + 16;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     strobe;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     truncated;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int words_sent;
    int runs_sent;
    int runs_over;

    binary_insertion_sorter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .is_last      (is_last),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .end_of_run   (end_of_run),
        .truncated    (truncated)
    );

    bis_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .is_last      (is_last),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .end_of_run   (end_of_run),
        .truncated    (truncated),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out waiting for the sorter.");
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly random patterns, with the extremes and a narrow band around
    // zero mixed in so that equal keys turn up often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic closes_run);
        int gap;
        gap = 0;
        // Words 30 to 74 of the whole test go without any gaps.
        if ((words_sent < 30 || words_sent >= 75) && $urandom_range(0, 99) < 22)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= closes_run;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    task automatic send_run(input logic signed [DATA_W-1:0] vals[$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
        runs_sent++;
        if (vals.size() > MAX_ITEMS)
            runs_over++;
    endtask

    task automatic send_random_run(input int len);
        logic signed [DATA_W-1:0] vals[$];
        repeat (len) vals.push_back(pick_value());
        send_run(vals);
    endtask

    initial
    begin
        int random_words;
        int len;
        cycle_count = 0;
        words_sent  = 0;
        runs_sent   = 0;
        runs_over   = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        is_last     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-word runs at both ends of the range.
        send_run('{MOST_NEG});
        send_run('{MOST_POS});
        // Extremes, zero, signs and repeated keys in one run.
        send_run('{32'sd5, -32'sd1, MOST_POS, 32'sd0, MOST_NEG, 32'sd5, -32'sd1, 32'sd1,
                   MOST_POS, 32'sd5});
        // Words arriving in descending and in ascending order.
        send_run('{32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1});
        send_run('{MOST_NEG, -32'sd2, 32'sd7, MOST_POS});

        // A run that fills the store and then overflows it, so that the
        // closing word itself is dropped.
        send_random_run(MAX_ITEMS + $urandom_range(1, 4));

        random_words = 0;
        while (random_words < 22) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            send_random_run(len);
            random_words += len;
        end
        start   <= 1'b0;
        is_last <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d runs from %0d words, %0d of them over capacity.",
                 runs_sent, words_sent, runs_over);
        $display("Checked %0d sorted result words.", checked);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
design/bis_pkg.sv
design/bis_cell.sv
design/binary_insertion_sorter_unit.sv
bench/bis_result_checker.sv
bench/tb_binary_insertion_sorter_unit.sv
